@@ design/tpc_pkg.sv @@
// shared constants, codes and controller/datapath command types
package tpc_pkg;

    localparam int SAMPLES_DEF = 16;
    localparam int POINTS      = 4;
    localparam int PT_W        = 2;
    localparam int DIV_BITS    = 27;
    localparam int STEP_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 15;

    localparam logic signed [34:0] SAFE_SQ   = 35'sd376996;
    localparam logic [23:0]        SCALE_MAX = 24'd8388607;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        PH_INIT    = 2'd0,
        PH_OFF     = 2'd1,
        PH_COLLECT = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_INVALID  = 3'd1,
        EV_STARTED  = 3'd2,
        EV_ABORT    = 3'd3,
        EV_PT_START = 3'd4,
        EV_PT_END   = 3'd5,
        EV_FINISHED = 3'd6
    } event_t;

    typedef struct packed {
        logic              capture;
        logic              safe_mul;
        logic              sample_wr;
        logic              med_step;
        logic              calib_wr;
        logic              div_load;
        logic              div_step;
        logic              div_wr;
        logic              div_axis;
        logic              map_mul;
        logic              out_load;
        logic              out_map;
        event_t            out_event;
        logic [STEP_W-1:0] step;
        logic [PT_W-1:0]   point;
    } dp_cmd_t;

    typedef struct packed {
        logic op;
        logic far;
        logic safe_inside;
    } dp_status_t;

endpackage

@@ design/tpc_if.sv @@
// request and response channel interfaces
interface tpc_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic [14:0]        cam_z;

    modport source (output valid, op, cam_x, cam_y, cam_z, input ready);
    modport sink   (input valid, op, cam_x, cam_y, cam_z, output ready);
endinterface

interface tpc_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_res;
    logic               map_valid;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;

    modport source (output valid, event_res, map_valid, screen_x, screen_y, input ready);
    modport sink   (input valid, event_res, map_valid, screen_x, screen_y, output ready);
endinterface

@@ design/tpc_datapath.sv @@
// sample stores, median search, scale divider, mapping multipliers, output register
module tpc_datapath #(
    parameter int SAMPLES = tpc_pkg::SAMPLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tpc_pkg::dp_cmd_t                cmd,
    output tpc_pkg::dp_status_t             status,
    input  logic                            in_op,
    input  logic signed [15:0]              in_x,
    input  logic signed [15:0]              in_y,
    input  logic [14:0]                     in_z,
    input  logic                            cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tpc_pkg::CFG_W-1:0]       cfg_data,
    output logic [2:0]                      event_res,
    output logic                            map_valid,
    output logic signed [15:0]              screen_x,
    output logic signed [15:0]              screen_y
);
    import tpc_pkg::*;

    localparam int IDX_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W = $clog2(SAMPLES + 1);
    localparam int HALF  = SAMPLES / 2;

    logic [14:0] dist_reg;
    logic [13:0] width_reg, height_reg;

    logic               op_reg;
    logic signed [15:0] x_reg, y_reg;
    logic [14:0]        z_reg;

    logic signed [15:0] smp_x [SAMPLES];
    logic signed [15:0] smp_y [SAMPLES];
    logic signed [15:0] cal_x [POINTS];
    logic signed [15:0] cal_y [POINTS];

    logic signed [15:0] med_x_reg, med_y_reg;
    logic signed [33:0] sq_x_reg, sq_y_reg;

    logic signed [15:0] off_x_reg, off_y_reg;
    logic signed [23:0] scale_x_reg, scale_y_reg;

    logic [DIV_BITS-1:0] div_num_reg;
    logic [16:0]         div_rem_reg;
    logic [16:0]         div_mag_reg;
    logic                div_neg_reg, div_zero_reg;

    logic signed [40:0] prod_x_reg, prod_y_reg;

    logic [2:0]         event_reg;
    logic               map_reg;
    logic signed [15:0] sx_reg, sy_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg   <= 15'd4096;
            width_reg  <= 14'd1920;
            height_reg <= 14'd1080;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIST:   dist_reg   <= cfg_data;
                CFG_WIDTH:  width_reg  <= cfg_data[13:0];
                CFG_HEIGHT: height_reg <= cfg_data[13:0];
                default:    ;
            endcase
        end
    end

    // transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= in_op;
            x_reg  <= in_x;
            y_reg  <= in_y;
            z_reg  <= in_z;
        end
    end

    assign status.op  = op_reg;
    assign status.far = (z_reg > dist_reg);

    // safety zone around the last calibrated point
    logic [PT_W-1:0]    prev_pt;
    logic signed [16:0] dx, dy;
    logic signed [34:0] sq_sum;

    assign prev_pt = cmd.point - PT_W'(1);
    assign dx      = 17'(x_reg) - 17'(cal_x[prev_pt]);
    assign dy      = 17'(y_reg) - 17'(cal_y[prev_pt]);
    assign sq_sum  = 35'(sq_x_reg) + 35'(sq_y_reg);
    assign status.safe_inside = (sq_sum < SAFE_SQ);

    always_ff @(posedge clk)
    begin
        if (cmd.safe_mul)
        begin
            sq_x_reg <= dx * dx;
            sq_y_reg <= dy * dy;
        end
    end

    // sample stores
    logic [IDX_W-1:0] smp_idx;
    assign smp_idx = cmd.step[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.sample_wr)
        begin
            smp_x[smp_idx] <= x_reg;
            smp_y[smp_idx] <= y_reg;
        end
    end

    // upper median: candidate with at most HALF below it and more than HALF at or below
    logic signed [15:0] cand_x, cand_y;
    logic [SAMPLES-1:0] lt_x, le_x, lt_y, le_y;
    logic [CNT_W-1:0]   n_lt_x, n_le_x, n_lt_y, n_le_y;

    assign cand_x = smp_x[smp_idx];
    assign cand_y = smp_y[smp_idx];

    always_comb
    begin
        for (int i = 0; i < SAMPLES; i++)
        begin
            lt_x[i] = (smp_x[i] < cand_x);
            le_x[i] = (smp_x[i] <= cand_x);
            lt_y[i] = (smp_y[i] < cand_y);
            le_y[i] = (smp_y[i] <= cand_y);
        end
    end

    assign n_lt_x = CNT_W'($countones(lt_x));
    assign n_le_x = CNT_W'($countones(le_x));
    assign n_lt_y = CNT_W'($countones(lt_y));
    assign n_le_y = CNT_W'($countones(le_y));

    always_ff @(posedge clk)
    begin
        if (cmd.med_step)
        begin
            if (n_lt_x <= CNT_W'(HALF) && n_le_x > CNT_W'(HALF))
                med_x_reg <= cand_x;
            if (n_lt_y <= CNT_W'(HALF) && n_le_y > CNT_W'(HALF))
                med_y_reg <= cand_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calib_wr)
        begin
            cal_x[cmd.point] <= med_x_reg;
            cal_y[cmd.point] <= med_y_reg;
        end
    end

    // restoring divider for the scale, one quotient bit per cycle
    logic signed [17:0] den_x, den_y, den_sel;
    logic [13:0]        pix_sel;
    logic [17:0]        den_abs;
    logic [17:0]        trial;
    logic               fits;
    logic [23:0]        quo_sat;
    logic signed [23:0] scale_res;

    assign den_x   = (18'(cal_x[1]) - 18'(cal_x[0])) + (18'(cal_x[3]) - 18'(cal_x[2]));
    assign den_y   = (18'(cal_y[2]) - 18'(cal_y[0])) + (18'(cal_y[3]) - 18'(cal_y[1]));
    assign den_sel = cmd.div_axis ? den_y : den_x;
    assign pix_sel = cmd.div_axis ? height_reg : width_reg;
    assign den_abs = den_sel[17] ? 18'(-den_sel) : 18'(den_sel);
    assign trial   = {div_rem_reg, div_num_reg[DIV_BITS-1]};
    assign fits    = (trial >= {1'b0, div_mag_reg});
    assign quo_sat = (div_num_reg > DIV_BITS'(SCALE_MAX)) ? SCALE_MAX : div_num_reg[23:0];
    assign scale_res = div_zero_reg ? 24'sd0 :
                       div_neg_reg  ? -$signed(quo_sat) : $signed(quo_sat);

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_num_reg  <= {pix_sel, 13'd0};
            div_rem_reg  <= '0;
            div_mag_reg  <= den_abs[16:0];
            div_neg_reg  <= den_sel[17];
            div_zero_reg <= (den_sel == 18'sd0);
        end
        else if (cmd.div_step)
        begin
            div_rem_reg <= fits ? 17'(trial - {1'b0, div_mag_reg}) : trial[16:0];
            div_num_reg <= {div_num_reg[DIV_BITS-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_x_reg <= '0;
            scale_y_reg <= '0;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
        end
        else if (cmd.div_wr)
        begin
            if (cmd.div_axis)
            begin
                scale_y_reg <= scale_res;
                off_x_reg   <= cal_x[0];
                off_y_reg   <= cal_y[0];
            end
            else
                scale_x_reg <= scale_res;
        end
    end

    // mapping
    always_ff @(posedge clk)
    begin
        if (cmd.map_mul)
        begin
            prod_x_reg <= (17'(x_reg) - 17'(off_x_reg)) * scale_x_reg;
            prod_y_reg <= (17'(y_reg) - 17'(off_y_reg)) * scale_y_reg;
        end
    end

    function automatic logic signed [15:0] sat_px(input logic signed [40:0] p);
        logic signed [28:0] q;
        q = 29'(p >>> 12);
        if (q > 29'sd32767)
            return 16'sd32767;
        else if (q < -29'sd32768)
            return -16'sd32768;
        else
            return q[15:0];
    endfunction

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            event_reg <= cmd.out_event;
            map_reg   <= cmd.out_map;
            sx_reg    <= cmd.out_map ? sat_px(prod_x_reg) : 16'sd0;
            sy_reg    <= cmd.out_map ? sat_px(prod_y_reg) : 16'sd0;
        end
    end

    assign event_res = event_reg;
    assign map_valid = map_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;

endmodule

@@ design/tpc_controller.sv @@
// calibration sequencer: phase, point and sample counts, datapath commands
module tpc_controller #(
    parameter int SAMPLES = tpc_pkg::SAMPLES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  tpc_pkg::dp_status_t  status,
    output tpc_pkg::dp_cmd_t     cmd
);
    import tpc_pkg::*;

    localparam int CNT_W = $clog2(SAMPLES + 1);

    typedef enum logic [10:0] {
        ST_IDLE     = 11'b00000000001,
        ST_DECIDE   = 11'b00000000010,
        ST_SAFE_MUL = 11'b00000000100,
        ST_SAFE_CMP = 11'b00000001000,
        ST_STORE    = 11'b00000010000,
        ST_MEDIAN   = 11'b00000100000,
        ST_MED_WR   = 11'b00001000000,
        ST_DIV_X    = 11'b00010000000,
        ST_DIV_MID  = 11'b00100000000,
        ST_DIV_Y    = 11'b01000000000,
        ST_RESULT   = 11'b10000000000
    } state_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [2:0]        pc_reg, pc_next;
    logic [CNT_W-1:0]  sc_reg, sc_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    event_t            ev_reg, ev_next;
    logic              map_reg, map_next;
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  sc_eff;
    logic              pts_full;

    assign pts_full = (pc_reg >= 3'(POINTS));
    assign sc_eff   = (sc_reg >= CNT_W'(SAMPLES)) ? '0 : sc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_INIT;
            pc_reg        <= '0;
            sc_reg        <= '0;
            cnt_reg       <= '0;
            ev_reg        <= EV_NONE;
            map_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pc_reg        <= pc_next;
            sc_reg        <= sc_next;
            cnt_reg       <= cnt_next;
            ev_reg        <= ev_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        pc_next        = pc_reg;
        sc_next        = sc_reg;
        cnt_next       = cnt_reg;
        ev_next        = ev_reg;
        map_next       = map_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.point      = pc_reg[PT_W-1:0];
        cmd.step       = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                ev_next    = EV_NONE;
                map_next   = 1'b0;
                state_next = ST_RESULT;
                if (status.op)
                begin
                    if (phase_reg == PH_DONE && !status.far)
                    begin
                        cmd.map_mul = 1'b1;
                        map_next    = 1'b1;
                    end
                end
                else if (phase_reg == PH_DONE)
                    ev_next = EV_INVALID;
                else if (phase_reg == PH_INIT)
                begin
                    pc_next    = '0;
                    sc_next    = '0;
                    phase_next = PH_OFF;
                    ev_next    = EV_STARTED;
                end
                else if (status.far)
                begin
                    if (pts_full)
                    begin
                        cmd.div_load = 1'b1;
                        cnt_next     = '0;
                        state_next   = ST_DIV_X;
                    end
                    else
                    begin
                        if (phase_reg == PH_COLLECT)
                        begin
                            phase_next = PH_OFF;
                            ev_next    = EV_ABORT;
                        end
                        sc_next = '0;
                    end
                end
                else if (pts_full)
                    ev_next = EV_NONE;
                else if (phase_reg == PH_OFF && pc_reg != 3'd0)
                    state_next = ST_SAFE_MUL;
                else
                    state_next = ST_STORE;
            end
            ST_SAFE_MUL:
            begin
                cmd.safe_mul = 1'b1;
                state_next   = ST_SAFE_CMP;
            end
            ST_SAFE_CMP:
            begin
                state_next = status.safe_inside ? ST_RESULT : ST_STORE;
            end
            ST_STORE:
            begin
                cmd.sample_wr = 1'b1;
                cmd.step      = STEP_W'(sc_eff);
                if (phase_reg != PH_COLLECT)
                    ev_next = EV_PT_START;
                phase_next = PH_COLLECT;
                sc_next    = sc_eff + CNT_W'(1);
                if (sc_eff == CNT_W'(SAMPLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MEDIAN;
                end
                else
                    state_next = ST_RESULT;
            end
            ST_MEDIAN:
            begin
                cmd.med_step = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(SAMPLES - 1))
                    state_next = ST_MED_WR;
            end
            ST_MED_WR:
            begin
                cmd.calib_wr = 1'b1;
                sc_next      = '0;
                pc_next      = pc_reg + 3'd1;
                phase_next   = PH_OFF;
                ev_next      = EV_PT_END;
                state_next   = ST_RESULT;
            end
            ST_DIV_X:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(DIV_BITS - 1))
                    state_next = ST_DIV_MID;
            end
            ST_DIV_MID:
            begin
                // store the x scale, then load the y operands
                cmd.div_wr   = 1'b1;
                cmd.div_axis = 1'b0;
                state_next   = ST_DIV_Y;
                cnt_next     = '0;
            end
            ST_DIV_Y:
            begin
                // load, one step per quotient bit, then store the y scale
                cmd.div_axis = 1'b1;
                cnt_next     = cnt_reg + STEP_W'(1);
                if (cnt_reg == '0)
                    cmd.div_load = 1'b1;
                else if (cnt_reg == STEP_W'(DIV_BITS + 1))
                begin
                    cmd.div_wr = 1'b1;
                    cnt_next   = '0;
                    phase_next = PH_DONE;
                    ev_next    = EV_FINISHED;
                    state_next = ST_RESULT;
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_RESULT:
            begin
                cmd.out_event = ev_reg;
                cmd.out_map   = map_reg;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/touch_point_calibrator_core.sv @@
// top level of the touch point calibrator
//
//  port    | dir   | contents
//  --------+-------+---------------------------------------------------
//  req     | sink  | op, cam_x, cam_y, cam_z: feed or map transaction
//  rsp     | src   | event_res, map_valid, screen_x, screen_y
//  cfg_*   | in    | write enable, register index, write data
//
// one transaction at a time; a feed that closes a point runs the median scan
// (one candidate a cycle against all held samples), the finishing feed runs
// the scale division for x and y
// (restoring divider, one quotient bit a cycle, shared by x and y scale)
// the result sits in an output register; a stalled rsp holds the block in its
// result step until taken
// reset clears phase, counters, offsets and scales; the sample and calibration
// stores are written before they are read and need no clearing
module touch_point_calibrator_core #(
    parameter int SAMPLES = tpc_pkg::SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tpc_req_if.sink                       req,
    tpc_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpc_pkg::CFG_W-1:0]     cfg_data
);
    import tpc_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    tpc_controller #(
        .SAMPLES (SAMPLES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // stores, median, divider, mapping and output payload
    tpc_datapath #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (req.op),
        .in_x      (req.cam_x),
        .in_y      (req.cam_y),
        .in_z      (req.cam_z),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .event_res (rsp.event_res),
        .map_valid (rsp.map_valid),
        .screen_x  (rsp.screen_x),
        .screen_y  (rsp.screen_y)
    );

endmodule
